@@ rtl/pwrfd_pkg.sv @@
// Shared types, constants and register codes of the pulse-width remote frame decoder.
package pwrfd_pkg;

    localparam int FRAME_BITS_DEF = 24;
    localparam int WIDTH_W        = 16;
    localparam int BYTE_W         = 8;
    localparam int RESULT_W       = 3 * BYTE_W;
    localparam int OUT_DATA_W     = 32;
    localparam int CFG_ADDR_W     = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [WIDTH_W-1:0] LONG_MIN_RST  = 16'd55;
    localparam logic [WIDTH_W-1:0] LONG_MAX_RST  = 16'd65;
    localparam logic [WIDTH_W-1:0] SHORT_MIN_RST = 16'd15;
    localparam logic [WIDTH_W-1:0] SHORT_MAX_RST = 16'd25;
    localparam logic [WIDTH_W-1:0] SYNC_MIN_RST  = 16'd633;
    localparam logic [BYTE_W-1:0]  MATCH_ADDRESS_RST = 8'd251;
    localparam logic [BYTE_W-1:0]  MATCH_DATA_RST    = 8'd37;
    localparam logic [BYTE_W-1:0]  MATCH_COMMAND_RST = 8'd213;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_LONG_MIN      = 3'd0,
        CFG_LONG_MAX      = 3'd1,
        CFG_SHORT_MIN     = 3'd2,
        CFG_SHORT_MAX     = 3'd3,
        CFG_SYNC_MIN      = 3'd4,
        CFG_MATCH_ADDRESS = 3'd5,
        CFG_MATCH_DATA    = 3'd6,
        CFG_MATCH_COMMAND = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HIGH = 2'd1,
        PH_LOW  = 2'd2
    } phase_t;

    typedef struct packed {
        logic [WIDTH_W-1:0] long_min;
        logic [WIDTH_W-1:0] long_max;
        logic [WIDTH_W-1:0] short_min;
        logic [WIDTH_W-1:0] short_max;
        logic [WIDTH_W-1:0] sync_min;
        logic [BYTE_W-1:0]  match_address;
        logic [BYTE_W-1:0]  match_data;
        logic [BYTE_W-1:0]  match_command;
    } cfg_t;

    // Classified pulse as it travels through the queue
    typedef struct packed {
        logic level;
        logic is_long;
        logic is_short;
        logic is_sync;
    } pulse_class_t;

endpackage

@@ rtl/pwrfd_front.sv @@
// Front end: compare one pulse width against the configured windows.
module pwrfd_front
(
    input  logic                            level,
    input  logic [pwrfd_pkg::WIDTH_W-1:0]   width,
    input  pwrfd_pkg::cfg_t                 cfg,
    output pwrfd_pkg::pulse_class_t         pulse_class
);

    // Strict bounds on both windows; the sync gap bound is inclusive
    always_comb
    begin
        pulse_class.level    = level;
        pulse_class.is_long  = (width > cfg.long_min) && (width < cfg.long_max);
        pulse_class.is_short = (width > cfg.short_min) && (width < cfg.short_max);
        pulse_class.is_sync  = (width >= cfg.sync_min);
    end

endmodule

@@ rtl/pwrfd_queue.sv @@
// Short FIFO of classified pulses between front end and back end.
module pwrfd_queue
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  pwrfd_pkg::pulse_class_t     push_data,
    output logic                        full,
    input  logic                        pop,
    output pwrfd_pkg::pulse_class_t     pop_data,
    output logic                        empty
);

    localparam int DEPTH = pwrfd_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    pwrfd_pkg::pulse_class_t mem [DEPTH];

    logic [PTR_W-1:0] wptr_reg;
    logic [PTR_W-1:0] wptr_next;
    logic [PTR_W-1:0] rptr_reg;
    logic [PTR_W-1:0] rptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

@@ rtl/pwrfd_back.sv @@
// Back end: frame state machine, bit shifter, match check and output register.
module pwrfd_back
#(
    parameter int FRAME_BITS = pwrfd_pkg::FRAME_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  pwrfd_pkg::cfg_t                     cfg,
    input  pwrfd_pkg::pulse_class_t             pulse_class,
    input  logic                                q_empty,
    output logic                                q_pop,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [pwrfd_pkg::OUT_DATA_W-1:0]    m_tdata
);

    localparam int CNT_W   = $clog2(FRAME_BITS + 1);
    localparam int FRAME_W = (FRAME_BITS > pwrfd_pkg::RESULT_W) ?
                             FRAME_BITS : pwrfd_pkg::RESULT_W;
    localparam int BW      = pwrfd_pkg::BYTE_W;

    pwrfd_pkg::phase_t              phase_reg;
    pwrfd_pkg::phase_t              phase_next;
    logic                           long_high_reg;
    logic                           long_high_next;
    logic [FRAME_BITS-1:0]          shift_reg;
    logic [FRAME_BITS-1:0]          shift_next;
    logic [CNT_W-1:0]               count_reg;
    logic [CNT_W-1:0]               count_next;
    logic                           led_reg;
    logic                           led_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [pwrfd_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic [pwrfd_pkg::OUT_DATA_W-1:0] out_data_next;
    logic [FRAME_W-1:0]             frame_ext;
    logic [BW-1:0]                  byte0;
    logic [BW-1:0]                  byte1;
    logic [BW-1:0]                  byte2;
    logic                           matched;
    logic                           bit_ok;

    // Take a pulse whenever the output slot is free or drains this cycle
    assign q_pop    = !q_empty && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        phase_next     = phase_reg;
        long_high_next = long_high_reg;
        shift_next     = shift_reg;
        count_next     = count_reg;
        led_next       = led_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        bit_ok         = long_high_reg ? pulse_class.is_short : pulse_class.is_long;
        frame_ext      = FRAME_W'({shift_reg[FRAME_BITS-2:0], long_high_reg});
        byte0          = frame_ext[3*BW-1:2*BW];
        byte1          = frame_ext[2*BW-1:BW];
        byte2          = frame_ext[BW-1:0];
        matched        = (byte0 == cfg.match_address) && (byte1 == cfg.match_data) &&
                         (byte2 == cfg.match_command);
        if (q_pop)
        begin
            case (phase_reg)
                pwrfd_pkg::PH_HIGH:
                begin
                    if (!pulse_class.level)
                    begin
                        phase_next = pwrfd_pkg::PH_IDLE;
                    end
                    else if (pulse_class.is_long)
                    begin
                        long_high_next = 1'b1;
                        phase_next     = pwrfd_pkg::PH_LOW;
                    end
                    else if (pulse_class.is_short)
                    begin
                        long_high_next = 1'b0;
                        phase_next     = pwrfd_pkg::PH_LOW;
                    end
                    else
                    begin
                        phase_next = pwrfd_pkg::PH_IDLE;
                    end
                end
                pwrfd_pkg::PH_LOW:
                begin
                    if (pulse_class.level || !bit_ok)
                    begin
                        phase_next = pwrfd_pkg::PH_IDLE;
                    end
                    else
                    begin
                        // A long high marks a 1; shift it in at the bottom
                        shift_next = {shift_reg[FRAME_BITS-2:0], long_high_reg};
                        count_next = count_reg + CNT_W'(1);
                        if (count_reg == CNT_W'(FRAME_BITS - 1))
                        begin
                            led_next       = led_reg ^ matched;
                            out_valid_next = 1'b1;
                            out_data_next  = {(pwrfd_pkg::OUT_DATA_W - 3*BW - 2)'(0),
                                              led_reg ^ matched, matched,
                                              byte2, byte1, byte0};
                            phase_next     = pwrfd_pkg::PH_IDLE;
                        end
                        else
                        begin
                            phase_next = pwrfd_pkg::PH_HIGH;
                        end
                    end
                end
                default:
                begin
                    // Idle: arm on a wide enough low gap, ignore anything else
                    phase_next = pwrfd_pkg::PH_IDLE;
                    if (!pulse_class.level && pulse_class.is_sync)
                    begin
                        shift_next     = '0;
                        count_next     = '0;
                        long_high_next = 1'b0;
                        phase_next     = pwrfd_pkg::PH_HIGH;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= pwrfd_pkg::PH_IDLE;
            long_high_reg <= 1'b0;
            shift_reg     <= '0;
            count_reg     <= '0;
            led_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            long_high_reg <= long_high_next;
            shift_reg     <= shift_next;
            count_reg     <= count_next;
            led_reg       <= led_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule

@@ rtl/pulse_width_remote_frame_decoder_top.sv @@
// Top level of the pulse-width remote frame decoder: config registers and stream ports.
//
// Each transfer on the slave stream is one finished pulse of the RF line: its
// width in timer ticks on s_tdata and its level on s_tuser. A low pulse at least
// sync_min ticks wide arms the decoder; after that pulses are read in high/low
// pairs, long high plus short low giving a 1 and short high plus long low a 0,
// with strict window bounds. Any pulse of the wrong level or outside its window
// drops the frame and returns to idle. After FRAME_BITS bits one result goes out
// on the master stream with the last 24 received bits as three bytes (first
// received bit most significant), a match flag against the three match
// registers, and the LED state, which toggles on every match. Pulses that finish
// no frame give no result. The block takes one pulse per clock while the queue
// has room: a compare stage classifies the pulse as it is accepted and writes it
// into a four-entry queue, and the frame state machine retires one queued pulse
// per cycle while no result is stalled, into a single output register. s_tready
// drops only when the queue is full, which happens only while the master side
// holds m_tready low with a result waiting. Write the configuration registers
// only while no pulse is queued or in flight.
module pulse_width_remote_frame_decoder_top
#(
    parameter int FRAME_BITS = pwrfd_pkg::FRAME_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // Pulse stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [15:0]                         s_tdata,   // [15:0] width
    input  logic                                s_tuser,   // [0] level
    // Result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [7:0] first_byte, [15:8] second_byte, [23:16] third_byte,
    // [24] matched, [25] led_on, [31:26] zero
    output logic [pwrfd_pkg::OUT_DATA_W-1:0]    m_tdata,
    // Configuration write port
    input  logic                                cfg_we,
    input  logic [pwrfd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [pwrfd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    pwrfd_pkg::cfg_t            cfg_reg;
    pwrfd_pkg::cfg_t            cfg_next;
    pwrfd_pkg::pulse_class_t    in_class;
    pwrfd_pkg::pulse_class_t    q_data;
    logic                       q_full;
    logic                       q_empty;
    logic                       q_pop;
    logic                       in_xfer;

    // Accept a pulse whenever the queue has room
    assign s_tready = !q_full;
    assign in_xfer  = s_tvalid && s_tready;

    // Config register file: 16-bit windows, 8-bit match bytes from the low bits
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (pwrfd_pkg::cfg_idx_t'(cfg_addr))
                pwrfd_pkg::CFG_LONG_MIN:      cfg_next.long_min      = cfg_wdata;
                pwrfd_pkg::CFG_LONG_MAX:      cfg_next.long_max      = cfg_wdata;
                pwrfd_pkg::CFG_SHORT_MIN:     cfg_next.short_min     = cfg_wdata;
                pwrfd_pkg::CFG_SHORT_MAX:     cfg_next.short_max     = cfg_wdata;
                pwrfd_pkg::CFG_SYNC_MIN:      cfg_next.sync_min      = cfg_wdata;
                pwrfd_pkg::CFG_MATCH_ADDRESS: cfg_next.match_address = cfg_wdata[7:0];
                pwrfd_pkg::CFG_MATCH_DATA:    cfg_next.match_data    = cfg_wdata[7:0];
                pwrfd_pkg::CFG_MATCH_COMMAND: cfg_next.match_command = cfg_wdata[7:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_min      <= pwrfd_pkg::LONG_MIN_RST;
            cfg_reg.long_max      <= pwrfd_pkg::LONG_MAX_RST;
            cfg_reg.short_min     <= pwrfd_pkg::SHORT_MIN_RST;
            cfg_reg.short_max     <= pwrfd_pkg::SHORT_MAX_RST;
            cfg_reg.sync_min      <= pwrfd_pkg::SYNC_MIN_RST;
            cfg_reg.match_address <= pwrfd_pkg::MATCH_ADDRESS_RST;
            cfg_reg.match_data    <= pwrfd_pkg::MATCH_DATA_RST;
            cfg_reg.match_command <= pwrfd_pkg::MATCH_COMMAND_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Classify the pulse on the way in
    pwrfd_front u_front
    (
        .level       (s_tuser),
        .width       (s_tdata),
        .cfg         (cfg_reg),
        .pulse_class (in_class)
    );

    // Decouple classification from the frame state machine
    pwrfd_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_xfer),
        .push_data (in_class),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    // Advance the frame, hold the result until the master side takes it
    pwrfd_back
    #(
        .FRAME_BITS (FRAME_BITS)
    )
    u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .pulse_class (q_data),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // A fresh result only ever follows a retired pulse
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(q_pop))
    else $error("result appeared without a retired pulse");

    // Never retire a pulse while a waiting result is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        !(q_pop && m_tvalid && !m_tready))
    else $error("pulse retired while output stalled");

    // A stalled input side means the queue is holding pulses for the back end
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> !q_empty)
    else $error("input stalled with empty queue");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the pulse-width remote frame decoder.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pwrfd_pkg::*;

    localparam int FRAME_LEN     = FRAME_BITS_DEF;
    localparam int SETTLE_CYCLES = 12;      // covers the output register and a full queue draining
    localparam int CYCLE_LIMIT   = 200000;

    // Result word as it leaves on m_tdata, lowest field last
    typedef struct packed {
        logic [5:0] pad;
        logic       led_on;
        logic       matched;
        logic [7:0] third_byte;
        logic [7:0] second_byte;
        logic [7:0] first_byte;
    } frame_result_t;

    // Predicts decoded frames from accepted pulses and checks the result stream
    class frame_scoreboard;
        logic [15:0]   long_lo, long_hi, short_lo, short_hi, sync_lo;
        logic [7:0]    want_addr, want_data, want_cmd;
        phase_t        phase;
        bit            long_high;
        logic [23:0]   shifted;
        int unsigned   nbits;
        bit            led;
        frame_result_t frames_q[$];
        int            errors;
        int            frames_made;

        function new();
            long_lo   = LONG_MIN_RST;
            long_hi   = LONG_MAX_RST;
            short_lo  = SHORT_MIN_RST;
            short_hi  = SHORT_MAX_RST;
            sync_lo   = SYNC_MIN_RST;
            want_addr = MATCH_ADDRESS_RST;
            want_data = MATCH_DATA_RST;
            want_cmd  = MATCH_COMMAND_RST;
            phase     = PH_IDLE;
            long_high = 1'b0;
            shifted   = '0;
            nbits     = 0;
            led       = 1'b0;
            errors    = 0;
            frames_made = 0;
        endfunction

        function bit is_long_width(logic [15:0] w);
            return (w > long_lo) && (w < long_hi);
        endfunction

        function bit is_short_width(logic [15:0] w);
            return (w > short_lo) && (w < short_hi);
        endfunction

        function void set_reg(cfg_idx_t idx, logic [15:0] v);
            case (idx)
                CFG_LONG_MIN:      long_lo   = v;
                CFG_LONG_MAX:      long_hi   = v;
                CFG_SHORT_MIN:     short_lo  = v;
                CFG_SHORT_MAX:     short_hi  = v;
                CFG_SYNC_MIN:      sync_lo   = v;
                CFG_MATCH_ADDRESS: want_addr = v[7:0];
                CFG_MATCH_DATA:    want_data = v[7:0];
                CFG_MATCH_COMMAND: want_cmd  = v[7:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return frames_q.size();
        endfunction

        // Advance the frame state by one accepted pulse
        function void note_pulse(logic lvl, logic [15:0] w);
            frame_result_t r;
            bit ok;
            case (phase)
                PH_HIGH:
                begin
                    if (!lvl)
                        phase = PH_IDLE;
                    else if (is_long_width(w))
                    begin
                        long_high = 1'b1;
                        phase = PH_LOW;
                    end
                    else if (is_short_width(w))
                    begin
                        long_high = 1'b0;
                        phase = PH_LOW;
                    end
                    else
                        phase = PH_IDLE;
                end
                PH_LOW:
                begin
                    ok = long_high ? is_short_width(w) : is_long_width(w);
                    if (lvl || !ok)
                        phase = PH_IDLE;
                    else
                    begin
                        shifted = {shifted[22:0], long_high};
                        nbits++;
                        if (nbits < FRAME_LEN)
                            phase = PH_HIGH;
                        else
                        begin
                            r.pad         = '0;
                            r.first_byte  = shifted[23:16];
                            r.second_byte = shifted[15:8];
                            r.third_byte  = shifted[7:0];
                            r.matched     = (shifted[23:16] == want_addr) &&
                                            (shifted[15:8] == want_data) &&
                                            (shifted[7:0] == want_cmd);
                            if (r.matched)
                                led = ~led;
                            r.led_on = led;
                            frames_q.push_back(r);
                            frames_made++;
                            phase = PH_IDLE;
                        end
                    end
                end
                default:
                begin
                    phase = PH_IDLE;
                    if (!lvl && w >= sync_lo)
                    begin
                        shifted   = '0;
                        nbits     = 0;
                        long_high = 1'b0;
                        phase     = PH_HIGH;
                    end
                end
            endcase
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(logic [31:0] raw);
            frame_result_t got, want;
            got = raw;
            if (frames_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: expected none, actual %h", $time, raw);
                return;
            end
            want = frames_q.pop_front();
            compare_field("first_byte", want.first_byte, got.first_byte);
            compare_field("second_byte", want.second_byte, got.second_byte);
            compare_field("third_byte", want.third_byte, got.third_byte);
            compare_field("matched", 8'(want.matched), 8'(got.matched));
            compare_field("led_on", 8'(want.led_on), 8'(got.led_on));
            compare_field("pad", 8'(want.pad), 8'(got.pad));
        endfunction
    endclass

    // Every input of the block starts from a known value
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic        cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = CFG_LONG_MIN;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    frame_scoreboard sb = new();
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int frame_items   = 0;
    int cycles        = 0;

    pulse_width_remote_frame_decoder_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #4 clk = ~clk;

    // Stall the result side at random; the rate follows the current segment
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= sink_idle_pct);

    // Check every result transfer against the oldest predicted frame
    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    // Offer one pulse after a random gap and hold it until the transfer happens.
    // Valid stays high between back-to-back pulses, so it is never dropped and
    // raised within one step.
    task automatic send_pulse(input logic lvl, input logic [15:0] w);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        s_tuser  <= lvl;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_pulse(lvl, w);
    endtask

    // Send one frame pulse; when spoiled, break its level or width
    task automatic send_shaped(input logic lvl, input logic [15:0] w,
                               input logic [15:0] lo, input logic [15:0] hi, input bit spoil);
        logic        l2;
        logic [15:0] w2;
        l2 = lvl;
        w2 = w;
        if (spoil)
            case ($urandom_range(3))
                0:       l2 = ~lvl;
                1:       w2 = lo;
                2:       w2 = hi;
                default: w2 = 16'($urandom);
            endcase
        send_pulse(l2, w2);
        frame_items++;
    endtask

    // Pick a width strictly inside (lo, hi), or any width when that window is empty
    function automatic logic [15:0] pick_between(logic [15:0] lo, logic [15:0] hi);
        if (hi > lo + 17'd1)
            return 16'($urandom_range(hi - 1, lo + 1));
        return 16'($urandom);
    endfunction

    // Short high pulse that the long window does not claim first, where possible
    function automatic logic [15:0] pick_short_high();
        logic [15:0] w;
        w = pick_between(sb.short_lo, sb.short_hi);
        repeat (8)
            if (sb.is_long_width(w))
                w = pick_between(sb.short_lo, sb.short_hi);
        return w;
    endfunction

    // Sync gap followed by FRAME_LEN high/low pairs, first bit most significant
    task automatic send_frame(input logic [23:0] bits, input bit broken);
        int          bad_at;
        int          i;
        bit          b;
        logic [15:0] w;
        bad_at = broken ? $urandom_range(2 * FRAME_LEN) : -1;
        w = $urandom_range(1) ? sb.sync_lo : 16'($urandom_range(65535, sb.sync_lo));
        send_shaped(1'b0, w, sb.sync_lo - 16'd1, sb.sync_lo, bad_at == 0);
        for (i = 0; i < FRAME_LEN; i++)
        begin
            b = bits[FRAME_LEN - 1 - i];
            if (b)
            begin
                send_shaped(1'b1, pick_between(sb.long_lo, sb.long_hi),
                            sb.long_lo, sb.long_hi, bad_at == 2 * i + 1);
                send_shaped(1'b0, pick_between(sb.short_lo, sb.short_hi),
                            sb.short_lo, sb.short_hi, bad_at == 2 * i + 2);
            end
            else
            begin
                send_shaped(1'b1, pick_short_high(),
                            sb.short_lo, sb.short_hi, bad_at == 2 * i + 1);
                send_shaped(1'b0, pick_between(sb.long_lo, sb.long_hi),
                            sb.long_lo, sb.long_hi, bad_at == 2 * i + 2);
            end
        end
    endtask

    // Mostly clean frames with random content; some broken ones and line noise
    task automatic run_segment(input int src_pct, input int sink_pct,
                               input int min_items, input int min_frames);
        int          start_items;
        int          start_frames;
        int          r;
        logic [23:0] bits;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        start_items   = frame_items;
        start_frames  = sb.frames_made;
        while (frame_items - start_items < min_items ||
               sb.frames_made - start_frames < min_frames)
        begin
            repeat ($urandom_range(2))
                send_pulse($urandom_range(99) < 70, 16'($urandom));
            r = $urandom_range(99);
            if (r < 35)
                bits = {sb.want_addr, sb.want_data, sb.want_cmd};
            else if (r < 50)
                bits = {sb.want_addr, sb.want_data, sb.want_cmd} ^ (24'd1 << $urandom_range(23));
            else
                bits = 24'($urandom);
            send_frame(bits, $urandom_range(99) < 20);
        end
    endtask

    // Drop valid, then wait for the last frame and the pulses still queued
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= v;
        @(posedge clk);
        sb.set_reg(idx, v);
    endtask

    // Write all registers; byte registers get junk in the unused upper bits
    task automatic apply_config(input logic [15:0] l_lo, input logic [15:0] l_hi,
                                input logic [15:0] s_lo, input logic [15:0] s_hi,
                                input logic [15:0] sy, input logic [7:0] addr,
                                input logic [7:0] data, input logic [7:0] cmd);
        write_reg(CFG_LONG_MIN, l_lo);
        write_reg(CFG_LONG_MAX, l_hi);
        write_reg(CFG_SHORT_MIN, s_lo);
        write_reg(CFG_SHORT_MAX, s_hi);
        write_reg(CFG_SYNC_MIN, sy);
        write_reg(CFG_MATCH_ADDRESS, {8'($urandom), addr});
        write_reg(CFG_MATCH_DATA, {8'($urandom), data});
        write_reg(CFG_MATCH_COMMAND, {8'($urandom), cmd});
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed pulses under the reset windows
        src_idle_pct  = 38;
        sink_idle_pct = 65;
        send_pulse(1'b1, 16'd0);        // high pulses in idle are ignored
        send_pulse(1'b1, 16'hFFFF);
        send_pulse(1'b0, 16'd632);      // one tick short of a sync gap
        send_pulse(1'b0, 16'd0);
        send_pulse(1'b0, 16'd633);      // sync exactly at the bound arms
        send_pulse(1'b0, 16'd700);      // wrong level aborts, not taken as sync
        send_pulse(1'b0, 16'hFFFF);     // widest sync
        send_pulse(1'b1, 16'd55);       // long bounds are strict
        send_pulse(1'b0, 16'd633);
        send_pulse(1'b1, 16'd65);
        send_pulse(1'b0, 16'd633);
        send_pulse(1'b1, 16'd60);
        send_pulse(1'b0, 16'd15);       // short bounds are strict
        send_pulse(1'b0, 16'd633);
        send_pulse(1'b1, 16'd20);
        send_pulse(1'b1, 16'd60);       // high where a low is due aborts
        send_pulse(1'b0, 16'd633);
        send_pulse(1'b1, 16'd20);
        send_pulse(1'b0, 16'd65);
        send_pulse(1'b0, 16'd700);
        send_pulse(1'b1, 16'd25);

        run_segment(38, 65, 390, 6);
        settle();

        // Wide windows, zero sync bound: every low pulse in idle arms
        apply_config(16'd200, 16'd300, 16'd0, 16'd100, 16'd0, 8'h00, 8'hFF, 8'hA5);
        run_segment(38, 65, 390, 6);
        settle();

        // Overlapping windows: a high pulse is tried as long first
        apply_config(16'd20, 16'd60, 16'd5, 16'd30, 16'd300, 8'h3C, 8'h81, 8'h7E);
        run_segment(65, 38, 390, 6);
        settle();

        // Windows at the top of the width range, sync only at saturation
        apply_config(16'd65000, 16'hFFFF, 16'd1000, 16'd1003, 16'hFFFF,
                     8'hFF, 8'h00, 8'h5A);
        run_segment(0, 0, 390, 6);
        settle();

        if (sb.errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
